[rtl/nbc_pkg.sv]
// shared constants for the niggli boundary classifier
// term layout between front and back, queue depth, csr map; no dependencies
package nbc_pkg;

   localparam int COMPONENT_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT     = 2;

   localparam int TOLERANCE_WIDTH = 31;
   localparam int MASK_WIDTH      = 15;

   // apb map: one 32-bit register per word
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_TOLERANCE = 1'b0;

   // differences and sums the front stage hands to the back stage
   localparam int T_D12  = 0;   // aa - bb
   localparam int T_D23  = 1;   // bb - cc
   localparam int T_G4   = 2;   // 2bc
   localparam int T_G5   = 3;   // 2ac
   localparam int T_G6   = 4;   // 2ab
   localparam int T_D24  = 5;   // bb - 2bc
   localparam int T_D56  = 6;   // 2ac - 2ab
   localparam int T_S24  = 7;   // bb + 2bc
   localparam int T_D15  = 8;   // aa - 2ac
   localparam int T_D46  = 9;   // 2bc - 2ab
   localparam int T_S15  = 10;  // aa + 2ac
   localparam int T_D16  = 11;  // aa - 2ab
   localparam int T_D45  = 12;  // 2bc - 2ac
   localparam int T_S16  = 13;  // aa + 2ab
   localparam int T_SF   = 14;  // aa + bb + 2bc + 2ac + 2ab
   localparam int NTERM  = 15;

   // wide enough for a five-term sum and for the tolerance compare
   function automatic int term_width(input int cw);
      int base;
      base = (cw > TOLERANCE_WIDTH) ? cw : TOLERANCE_WIDTH;
      return base + 4;
   endfunction

endpackage

[rtl/nbc_req_if.sv]
// input channel: one g6 vector per transfer
// depends on nbc_pkg for the default component width
interface nbc_req_if
   import nbc_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] g_aa;
   logic signed [COMPONENT_WIDTH-1:0] g_bb;
   logic signed [COMPONENT_WIDTH-1:0] g_cc;
   logic signed [COMPONENT_WIDTH-1:0] g_2bc;
   logic signed [COMPONENT_WIDTH-1:0] g_2ac;
   logic signed [COMPONENT_WIDTH-1:0] g_2ab;

   modport source (output valid, g_aa, g_bb, g_cc, g_2bc, g_2ac, g_2ab, input ready);
   modport sink   (input valid, g_aa, g_bb, g_cc, g_2bc, g_2ac, g_2ab, output ready);
endinterface

[rtl/nbc_rsp_if.sv]
// result channel: boundary hit mask and any-hit flag
// depends on nbc_pkg for the mask width
interface nbc_rsp_if
   import nbc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [MASK_WIDTH-1:0] boundary_mask;
   logic                  any_boundary;

   modport source (output valid, boundary_mask, any_boundary, input ready);
   modport sink   (input valid, boundary_mask, any_boundary, output ready);
endinterface

[rtl/nbc_front.sv]
// front stage: takes a g6 vector and registers all widened sums and differences
// depends on nbc_pkg and nbc_req_if
module nbc_front
   import nbc_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT,
   parameter int TW              = term_width(COMPONENT_WIDTH)
)(
   input  logic                clock,
   input  logic                reset,
   nbc_req_if.sink             req_chan,
   output logic                push_valid,
   input  logic                push_ready,
   output logic [NTERM*TW-1:0] push_data
);

   localparam int EXT = TW - COMPONENT_WIDTH;

   logic                front_valid_ff;
   logic                front_valid_in;
   logic [NTERM*TW-1:0] terms_ff;
   logic [NTERM*TW-1:0] terms_in;
   logic                req_fire;

   logic signed [TW-1:0] g1, g2, g3, g4, g5, g6;
   logic signed [TW-1:0] s12, s45;

   assign g1 = signed'({{EXT{req_chan.g_aa[COMPONENT_WIDTH-1]}},  req_chan.g_aa});
   assign g2 = signed'({{EXT{req_chan.g_bb[COMPONENT_WIDTH-1]}},  req_chan.g_bb});
   assign g3 = signed'({{EXT{req_chan.g_cc[COMPONENT_WIDTH-1]}},  req_chan.g_cc});
   assign g4 = signed'({{EXT{req_chan.g_2bc[COMPONENT_WIDTH-1]}}, req_chan.g_2bc});
   assign g5 = signed'({{EXT{req_chan.g_2ac[COMPONENT_WIDTH-1]}}, req_chan.g_2ac});
   assign g6 = signed'({{EXT{req_chan.g_2ab[COMPONENT_WIDTH-1]}}, req_chan.g_2ab});

   assign s12 = g1 + g2;
   assign s45 = g4 + g5;

   always_comb begin
      terms_in = '0;
      terms_in[T_D12*TW +: TW] = g1 - g2;
      terms_in[T_D23*TW +: TW] = g2 - g3;
      terms_in[T_G4*TW  +: TW] = g4;
      terms_in[T_G5*TW  +: TW] = g5;
      terms_in[T_G6*TW  +: TW] = g6;
      terms_in[T_D24*TW +: TW] = g2 - g4;
      terms_in[T_D56*TW +: TW] = g5 - g6;
      terms_in[T_S24*TW +: TW] = g2 + g4;
      terms_in[T_D15*TW +: TW] = g1 - g5;
      terms_in[T_D46*TW +: TW] = g4 - g6;
      terms_in[T_S15*TW +: TW] = g1 + g5;
      terms_in[T_D16*TW +: TW] = g1 - g6;
      terms_in[T_D45*TW +: TW] = g4 - g5;
      terms_in[T_S16*TW +: TW] = g1 + g6;
      terms_in[T_SF*TW  +: TW] = s12 + s45 + g6;
   end

   // stage frees up whenever the queue takes what it holds
   assign req_chan.ready = !front_valid_ff || push_ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (req_fire) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         terms_ff <= terms_in;
      end
   end

   assign push_valid = front_valid_ff;
   assign push_data  = terms_ff;

endmodule

[rtl/nbc_queue.sv]
// short register queue between the front and back stages
// depends on nbc_pkg for the default depth
module nbc_queue
   import nbc_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = QUEUE_DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff,  count_in;
   logic                  push_fire;
   logic                  pop_fire;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && !push_fire) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop without push did not lower the count");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> pop_valid)
      else $error("queue empty right after a push");

endmodule

[rtl/nbc_back.sv]
// back stage: tolerance compares on the queued terms, mask assembly, result register
// depends on nbc_pkg and nbc_rsp_if
module nbc_back
   import nbc_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT,
   parameter int TW              = term_width(COMPONENT_WIDTH)
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  logic [NTERM*TW-1:0]        pop_data,
   input  logic [TOLERANCE_WIDTH-1:0] tolerance,
   nbc_rsp_if.source                  rsp_chan
);

   logic signed [TW-1:0]  term [NTERM];
   logic signed [TW-1:0]  tol_pos;
   logic signed [TW-1:0]  tol_neg;
   logic [NTERM-1:0]      le_tol;
   logic [NTERM-1:0]      ge_ntol;
   logic [NTERM-1:0]      near;
   logic [MASK_WIDTH-1:0] mask_in;
   logic [MASK_WIDTH-1:0] mask_ff;
   logic                  any_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  pop_fire;

   assign tol_pos = signed'({{(TW-TOLERANCE_WIDTH){1'b0}}, tolerance});
   assign tol_neg = -tol_pos;

   always_comb begin
      for (int i = 0; i < NTERM; i++) begin
         term[i]    = signed'(pop_data[i*TW +: TW]);
         le_tol[i]  = (term[i] <= tol_pos);
         ge_ntol[i] = (term[i] >= tol_neg);
         near[i]    = le_tol[i] && ge_ntol[i];
      end
   end

   always_comb begin
      mask_in      = '0;
      mask_in[0]   = near[T_D12];
      mask_in[1]   = near[T_D23];
      mask_in[2]   = near[T_G4];
      mask_in[3]   = near[T_G5];
      mask_in[4]   = near[T_G6];
      mask_in[5]   = near[T_D24] && ge_ntol[T_D56];
      mask_in[6]   = near[T_D24] && le_tol[T_D56];
      mask_in[7]   = near[T_S24];
      mask_in[8]   = near[T_D15] && ge_ntol[T_D46];
      mask_in[9]   = near[T_D15] && le_tol[T_D46];
      mask_in[10]  = near[T_S15];
      mask_in[11]  = near[T_D16] && ge_ntol[T_D45];
      mask_in[12]  = near[T_D16] && le_tol[T_D45];
      mask_in[13]  = near[T_S16];
      mask_in[14]  = near[T_SF];
   end

   // output register parts the queue from the result sink
   assign pop_ready = !rsp_valid_ff || rsp_chan.ready;
   assign pop_fire  = pop_valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         mask_ff <= mask_in;
         any_ff  <= |mask_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.boundary_mask = mask_ff;
   assign rsp_chan.any_boundary  = any_ff;

   a_any_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (any_ff == (|mask_ff)))
      else $error("any-hit flag disagrees with mask");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_refill_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop_fire |=> rsp_valid_ff)
      else $error("popped item did not reach the result register");

endmodule

[rtl/niggli_boundary_classify.sv]
// niggli boundary classifier top level: front stage, queue, back stage, tolerance csr
// path: the front register loads at the req transfer edge, then the queue slot, then the
// result register; a full queue or result back-pressure can hold an item between them
// throughput: one vector per cycle while results are taken; the queue absorbs result back-pressure so the
// front keeps taking vectors until both the queue and the front register are full
// reset: synchronous, active high; clears all valid state and sets tolerance to 0
module niggli_boundary_classify
   import nbc_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT
)(
   input  logic                      clock,
   input  logic                      reset,
   nbc_req_if.sink                   req_chan,
   nbc_rsp_if.source                 rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int TW = term_width(COMPONENT_WIDTH);

   logic [TOLERANCE_WIDTH-1:0] tolerance_ff;
   logic [TOLERANCE_WIDTH-1:0] tolerance_in;
   logic                       reg_sel;
   logic                       csr_write;

   logic                push_valid;
   logic                push_ready;
   logic [NTERM*TW-1:0] push_data;
   logic                pop_valid;
   logic                pop_ready;
   logic [NTERM*TW-1:0] pop_data;

   // register decode: word index from the upper address bits
   assign pready    = 1'b1;
   assign reg_sel   = (paddr[CSR_ADDR_WIDTH-1:2] == REG_TOLERANCE);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      tolerance_in = tolerance_ff;
      if (csr_write && reg_sel) begin
         tolerance_in = pwdata[TOLERANCE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= '0;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   assign prdata = reg_sel ? {{(CSR_DATA_WIDTH-TOLERANCE_WIDTH){1'b0}}, tolerance_ff} : '0;

   nbc_front #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .TW              (TW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   nbc_queue #(
      .DATA_WIDTH (NTERM*TW),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   nbc_back #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .TW              (TW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .tolerance (tolerance_ff),
      .rsp_chan  (rsp_chan)
   );

endmodule

[test/testbench.sv]
// testbench for niggli_boundary_classify: directed and random g6 vectors with an own
// predictor of the 15 boundary tests, tolerance written over apb between phases
// depends on nbc_pkg, nbc_req_if, nbc_rsp_if and the rtl top level
`timescale 1ns / 100ps

module testbench;
   import nbc_pkg::*;

   localparam int CW = COMPONENT_WIDTH_DEFAULT;
   localparam logic [CSR_ADDR_WIDTH-1:0] TOLERANCE_ADDR = CSR_ADDR_WIDTH'(4 * REG_TOLERANCE);
   localparam logic [CSR_ADDR_WIDTH-1:0] UNMAPPED_ADDR  = CSR_ADDR_WIDTH'(4);
   localparam longint COMP_MAX = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint COMP_MIN = -(longint'(1) <<< (CW - 1));
   localparam logic [TOLERANCE_WIDTH-1:0] TOL_MAX = '1;

   typedef logic signed [CW-1:0] comp_type;

   typedef struct {
      comp_type aa;
      comp_type bb;
      comp_type cc;
      comp_type bc;
      comp_type ac;
      comp_type ab;
   } g6_vec_type;

   typedef struct {
      logic [MASK_WIDTH-1:0] boundary_mask;
      logic                  any_boundary;
   } boundary_hits_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   nbc_req_if #(.COMPONENT_WIDTH(CW)) req_bus ();
   nbc_rsp_if rsp_bus ();

   niggli_boundary_classify #(.COMPONENT_WIDTH(CW)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   boundary_hits_type expected_hits[$];
   logic [TOLERANCE_WIDTH-1:0] tolerance_q;
   int  error_count;
   bit  send_burst;
   bit  sink_burst;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

   // |d| <= t
   function automatic bit within_tol(input longint d, input longint t);
      return (d <= t) && (d >= -t);
   endfunction

   function automatic boundary_hits_type classify_g6(input g6_vec_type v,
                                                     input logic [TOLERANCE_WIDTH-1:0] tol);
      longint aa, bb, cc, bc, ac, ab, t;
      bit     e24, e15, e16;
      boundary_hits_type r;
      aa = v.aa; bb = v.bb; cc = v.cc;
      bc = v.bc; ac = v.ac; ab = v.ab;
      t  = longint'(tol);
      e24 = within_tol(bb - bc, t);
      e15 = within_tol(aa - ac, t);
      e16 = within_tol(aa - ab, t);
      r.boundary_mask[0]  = within_tol(aa - bb, t);
      r.boundary_mask[1]  = within_tol(bb - cc, t);
      r.boundary_mask[2]  = within_tol(bc, t);
      r.boundary_mask[3]  = within_tol(ac, t);
      r.boundary_mask[4]  = within_tol(ab, t);
      r.boundary_mask[5]  = e24 && (ac - ab >= -t);
      r.boundary_mask[6]  = e24 && (ac - ab <= t);
      r.boundary_mask[7]  = within_tol(bb + bc, t);
      r.boundary_mask[8]  = e15 && (bc - ab >= -t);
      r.boundary_mask[9]  = e15 && (bc - ab <= t);
      r.boundary_mask[10] = within_tol(aa + ac, t);
      r.boundary_mask[11] = e16 && (bc - ac >= -t);
      r.boundary_mask[12] = e16 && (bc - ac <= t);
      r.boundary_mask[13] = within_tol(aa + ab, t);
      r.boundary_mask[14] = within_tol(aa + bb + bc + ac + ab, t);
      r.any_boundary = |r.boundary_mask;
      return r;
   endfunction

   function automatic g6_vec_type make_g6(input longint aa, bb, cc, bc, ac, ab);
      g6_vec_type v;
      v.aa = CW'(aa); v.bb = CW'(bb); v.cc = CW'(cc);
      v.bc = CW'(bc); v.ac = CW'(ac); v.ab = CW'(ab);
      return v;
   endfunction

   function automatic comp_type rand_component();
      longint x;
      case ($urandom_range(0, 4))
         0: x = longint'($signed($urandom));
         1: x = longint'($urandom_range(0, 128)) - 64;
         2: begin
            case ($urandom_range(0, 4))
               0: x = COMP_MAX;
               1: x = COMP_MIN;
               2: x = 0;
               3: x = -1;
               default: x = 1;
            endcase
         end
         default: x = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      endcase
      return CW'(x);
   endfunction

   // offset that lands on, just inside or just outside the tolerance band
   function automatic longint tol_offset(input logic [TOLERANCE_WIDTH-1:0] tol);
      longint t;
      t = longint'(tol);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return t;
         2: return -t;
         3: return t + 1;
         4: return -(t + 1);
         default: return ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(0, tol));
      endcase
   endfunction

   function automatic g6_vec_type rand_g6(input logic [TOLERANCE_WIDTH-1:0] tol);
      g6_vec_type v;
      longint     o;
      int         n;
      v.aa = rand_component(); v.bb = rand_component(); v.cc = rand_component();
      v.bc = rand_component(); v.ac = rand_component(); v.ab = rand_component();
      // most vectors get one or more components tied near a boundary
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < n; i++) begin
         o = tol_offset(tol);
         case ($urandom_range(0, 14))
            0:  v.bb = CW'(v.aa + o);
            1:  v.cc = CW'(v.bb + o);
            2:  v.bc = CW'(v.bb + o);
            3:  v.bc = CW'(-v.bb + o);
            4:  v.ac = CW'(v.aa + o);
            5:  v.ac = CW'(-v.aa + o);
            6:  v.ab = CW'(v.aa + o);
            7:  v.ab = CW'(-v.aa + o);
            8:  v.ac = CW'(v.ab + o);
            9:  v.bc = CW'(v.ab + o);
            10: v.bc = CW'(v.ac + o);
            11: v.ab = CW'(o - (v.aa + v.bb + v.bc + v.ac));
            12: v.bc = CW'(o);
            13: v.ac = CW'(o);
            default: v.ab = CW'(o);
         endcase
      end
      return v;
   endfunction

   // predictions are taken at the transfer edge with the tolerance then in force
   always @(posedge clock) begin
      g6_vec_type v;
      if (!reset && req_bus.valid && req_bus.ready) begin
         v.aa = req_bus.g_aa; v.bb = req_bus.g_bb; v.cc = req_bus.g_cc;
         v.bc = req_bus.g_2bc; v.ac = req_bus.g_2ac; v.ab = req_bus.g_2ab;
         expected_hits.insert(expected_hits.size(), classify_g6(v, tolerance_q));
      end
   end

   always @(posedge clock) begin
      boundary_hits_type exp_hits;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result transfer: boundary_mask %h", rsp_bus.boundary_mask);
            error_count++;
         end else begin
            exp_hits = expected_hits.pop_front();
            if (rsp_bus.boundary_mask !== exp_hits.boundary_mask) begin
               $error("boundary_mask: expected %h, got %h",
                      exp_hits.boundary_mask, rsp_bus.boundary_mask);
               error_count++;
            end
            if (rsp_bus.any_boundary !== exp_hits.any_boundary) begin
               $error("any_boundary: expected %b, got %b",
                      exp_hits.any_boundary, rsp_bus.any_boundary);
               error_count++;
            end
         end
      end
   end

   // result side: random stall before each transfer, none while sink_burst is set
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = sink_burst ? 0 : $urandom_range(0, 10);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   task automatic send_g6(input g6_vec_type v);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.g_aa  <= v.aa;
      req_bus.g_bb  <= v.bb;
      req_bus.g_cc  <= v.cc;
      req_bus.g_2bc <= v.bc;
      req_bus.g_2ac <= v.ac;
      req_bus.g_2ab <= v.ab;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == TOLERANCE_ADDR) tolerance_q = data[TOLERANCE_WIDTH-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_WIDTH-1:0] addr,
                           output logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_tolerance_reg();
      logic [CSR_DATA_WIDTH-1:0] rd;
      csr_read(TOLERANCE_ADDR, rd);
      if (rd !== CSR_DATA_WIDTH'(tolerance_q)) begin
         $error("tolerance: expected %h, got %h", CSR_DATA_WIDTH'(tolerance_q), rd);
         error_count++;
      end
   endtask

   task automatic test_csr_access();
      check_tolerance_reg();
      // top bit is beyond the register and must be dropped
      csr_write(TOLERANCE_ADDR, 32'h8000_0005);
      check_tolerance_reg();
      csr_write(UNMAPPED_ADDR, 32'h0000_0123);
      check_tolerance_reg();
      csr_write(TOLERANCE_ADDR, 32'h0);
      check_tolerance_reg();
   endtask

   task automatic test_directed_boundaries();
      send_burst = 1'b0;
      sink_burst = 1'b0;
      csr_write(TOLERANCE_ADDR, 32'h0);
      send_g6(make_g6(0, 0, 0, 0, 0, 0));
      send_g6(make_g6(100, 200, 300, 7, 11, 13));
      send_g6(make_g6(100, 100, 300, 7, 11, 13));
      send_g6(make_g6(100, 200, 200, 7, 11, 13));
      send_g6(make_g6(100, 200, 300, 0, 11, 13));
      send_g6(make_g6(100, 200, 300, 7, 0, 13));
      send_g6(make_g6(100, 200, 300, 7, 11, 0));
      // bb = 2bc with the tie-break going either way, and level
      send_g6(make_g6(100, 200, 300, 200, 11, 13));
      send_g6(make_g6(100, 200, 300, 200, 13, 11));
      send_g6(make_g6(100, 200, 300, 200, 12, 12));
      send_g6(make_g6(100, 200, 300, -200, 11, 13));
      send_g6(make_g6(100, 200, 300, 7, 100, 13));
      send_g6(make_g6(100, 200, 300, 17, 100, 13));
      send_g6(make_g6(100, 200, 300, 7, -100, 13));
      send_g6(make_g6(100, 200, 300, 7, 11, 100));
      send_g6(make_g6(100, 200, 300, 17, 11, 100));
      send_g6(make_g6(100, 200, 300, 7, 11, -100));
      send_g6(make_g6(100, 200, 300, 7, 11, -318));
      send_g6(make_g6(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
      send_g6(make_g6(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
      send_g6(make_g6(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN));
      wait_idle();
      // tolerance band edges, then the widest tolerance on extreme vectors
      csr_write(TOLERANCE_ADDR, 32'd5);
      send_g6(make_g6(1000, 1005, 3000, -5, 6, 40));
      send_g6(make_g6(1000, 1006, 3000, -6, 5, 40));
      wait_idle();
      csr_write(TOLERANCE_ADDR, CSR_DATA_WIDTH'(TOL_MAX));
      send_g6(make_g6(COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX));
      send_g6(make_g6(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
      wait_idle();
   endtask

   task automatic test_random_vectors(input int count,
                                      input logic [TOLERANCE_WIDTH-1:0] tol);
      csr_write(TOLERANCE_ADDR, CSR_DATA_WIDTH'(tol));
      check_tolerance_reg();
      for (int i = 0; i < count; i++) begin
         // stretches with no gaps on either side
         if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
         if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
         send_g6(rand_g6(tolerance_q));
      end
      wait_idle();
   endtask

   task automatic test_back_to_back(input int count);
      csr_write(TOLERANCE_ADDR, CSR_DATA_WIDTH'($urandom_range(0, 1 << 16)));
      send_burst = 1'b1;
      sink_burst = 1'b1;
      for (int i = 0; i < count; i++) begin
         // second half: full-rate sender against a stalling receiver
         if (i == count / 2) sink_burst = 1'b0;
         send_g6(rand_g6(tolerance_q));
      end
      wait_idle();
      send_burst = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_bus.valid = 1'b0;
      req_bus.g_aa  = '0;
      req_bus.g_bb  = '0;
      req_bus.g_cc  = '0;
      req_bus.g_2bc = '0;
      req_bus.g_2ac = '0;
      req_bus.g_2ab = '0;
      tolerance_q   = '0;
      error_count   = 0;
      send_burst    = 1'b0;
      sink_burst    = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_csr_access();
      test_directed_boundaries();
      test_random_vectors(200, '0);
      test_random_vectors(200, TOLERANCE_WIDTH'(1));
      test_random_vectors(200, TOLERANCE_WIDTH'(1 << 16));
      test_random_vectors(200, TOLERANCE_WIDTH'($urandom));
      test_random_vectors(200, TOL_MAX);
      test_random_vectors(150, TOLERANCE_WIDTH'($urandom_range(0, 255)));
      test_back_to_back(150);

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/nbc_pkg.sv
rtl/nbc_req_if.sv
rtl/nbc_rsp_if.sv
rtl/nbc_front.sv
rtl/nbc_queue.sv
rtl/nbc_back.sv
rtl/niggli_boundary_classify.sv
test/testbench.sv
